>>> src/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the sorted priority queue
// no dependencies; used by spq_cell and sorted_priority_queue_top

package spq_pkg;

  // number of cells in the chain
  localparam int CAPACITY = 16;

  // field widths
  localparam int VALUE_W = 32;
  localparam int PRIO_W = 16;
  localparam int REQ_W = 2;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 5;

  // held count must reach CAPACITY itself
  localparam int COUNT_W = $clog2(CAPACITY + 1);

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // one stored entry
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> src/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// sorted priority queue top level: request decode, chain of cells, result register
// depends on spq_pkg and spq_cell
//
//  channel | ports                          | payload (low bit first)
//  --------+--------------------------------+------------------------------------
//  request | in_tvalid in_tready in_tdata   | tdata: item_value, item_priority
//          | in_tuser                       | tuser: req_type
//  result  | out_tvalid out_tready out_tdata| tdata: front_value, entry_count
//          | out_tuser                      | tuser: status
//
// every cell compares its priority with the incoming one at once and shifts in the
// same edge, so a request is taken in every cycle while the result register is
// empty or being drained.
// the result register holds one finished transaction; a stall on the result
// side holds in_tready low until it is taken.
// rst_n is synchronous and empties the queue; cell contents are left as they are.

module sorted_priority_queue_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [47:0] in_tdata,   // [31:0] item_value, [47:32] item_priority
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // [31:0] front_value, [36:32] entry_count, rest zero
  output      logic [1:0]  out_tuser   // [1:0] status
);

  localparam int N = spq_pkg::CAPACITY;
  localparam int CW = spq_pkg::COUNT_W;

  logic in_fire;
  logic [spq_pkg::REQ_W-1:0] req_type;
  spq_pkg::entry_t new_entry;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic signed [spq_pkg::VALUE_W-1:0] front_r;
  logic signed [spq_pkg::VALUE_W-1:0] front_nxt;
  logic [spq_pkg::STATUS_W-1:0] status_r;
  logic [spq_pkg::STATUS_W-1:0] status_nxt;
  logic [spq_pkg::ECOUNT_W-1:0] ecount_r;
  logic [CW+spq_pkg::ECOUNT_W-1:0] count_wide;

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t cell_entry [N];
  logic [N-1:0] cell_stay;
  logic [N-1:0] occupied;
  logic is_empty;
  logic is_full;

  // request handshake and field unpacking
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire = in_tvalid && in_tready;
  assign req_type = in_tuser;
  assign new_entry.value = in_tdata[31:0];
  assign new_entry.prio = in_tdata[47:32];

  assign is_empty = (count_r == '0);
  assign is_full = (count_r == CW'(N));

  // request decode: shift commands, result fields, next count
  always_comb begin
    ctrl = '{push: 1'b0, pop: 1'b0};
    front_nxt = front_r;
    status_nxt = status_r;
    count_nxt = count_r;
    if (in_fire) begin
      front_nxt = '0;
      status_nxt = spq_pkg::ST_OK;
      unique case (req_type)
        spq_pkg::REQ_PUSH: begin
          if (is_full) begin
            status_nxt = spq_pkg::ST_FULL;
          end else begin
            ctrl.push = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        spq_pkg::REQ_POP: begin
          if (is_empty) begin
            status_nxt = spq_pkg::ST_EMPTY;
          end else begin
            ctrl.pop = 1'b1;
            front_nxt = cell_entry[0].value;
            count_nxt = count_r - CW'(1);
          end
        end
        spq_pkg::REQ_PEEK: begin
          if (is_empty) begin
            status_nxt = spq_pkg::ST_EMPTY;
          end else begin
            front_nxt = cell_entry[0].value;
          end
        end
        default: begin
          status_nxt = spq_pkg::ST_OK;
        end
      endcase
    end
  end

  // chain of cells, front at index 0
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign occupied[i] = (CW'(i) < count_r);
    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupied[i]),
      .new_entry  (new_entry),
      .left_entry ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i-1]),
      .left_stay  ((i == 0) ? 1'b1 : cell_stay[(i == 0) ? 0 : i-1]),
      .right_entry(cell_entry[(i == N-1) ? i : i+1]),
      .entry      (cell_entry[i]),
      .stay       (cell_stay[i])
    );
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // entry_count field is the low bits of the held count
  assign count_wide = {{spq_pkg::ECOUNT_W{1'b0}}, count_nxt};

  // result payload
  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    status_r <= status_nxt;
    if (in_fire) begin
      ecount_r <= count_wide[spq_pkg::ECOUNT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {3'b000, ecount_r, front_r};
  assign out_tuser = status_r;

endmodule

`default_nettype wire

>>> src/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one cell of the sorted chain: holds an entry and trades it with its neighbors
// depends on spq_pkg

module spq_cell (
  input  wire logic              clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire logic              occupied,
  input  wire spq_pkg::entry_t   new_entry,
  input  wire spq_pkg::entry_t   left_entry,
  input  wire logic              left_stay,
  input  wire spq_pkg::entry_t   right_entry,
  output      spq_pkg::entry_t   entry,
  output      logic              stay
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // held entry outranks the incoming one, so it keeps its place
  assign stay = occupied && (entry_r.prio > new_entry.prio);

  // next content: keep, take the new entry, or shift from a neighbor
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push) begin
      if (!stay) begin
        entry_nxt = left_stay ? new_entry : left_entry;
      end
    end else if (ctrl.pop) begin
      entry_nxt = right_entry;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

>>> tb/sv/tb_sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// self-checking testbench for sorted_priority_queue_top: directed table, then random
// push/pop/peek bursts under varied stream backpressure; depends on spq_pkg and the rtl

module tb_sorted_priority_queue_top;

  // request code with no operation behind it
  localparam logic [spq_pkg::REQ_W-1:0] REQ_NOP = 2'd3;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 250;

  // one result as the block returns it
  typedef struct packed {
    logic signed [spq_pkg::VALUE_W-1:0] front;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::ECOUNT_W-1:0] count;
  } result_t;

  // one request, with an optional hand-written answer
  typedef struct packed {
    logic [spq_pkg::REQ_W-1:0] req;
    logic signed [spq_pkg::VALUE_W-1:0] value;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic typed;
    result_t answer;
  } request_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [47:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tready = 1'b0;
  logic in_tready;
  logic out_tvalid;
  logic [39:0] out_tdata;
  logic [1:0] out_tuser;

  sorted_priority_queue_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  // shadow copy of the sorted store
  spq_pkg::entry_t shadow_store [spq_pkg::CAPACITY];
  int shadow_count = 0;

  request_row_t directed_rows[$];
  request_row_t rows_in_flight[$];
  result_t pending_results[$];
  int mismatches = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_pending = 1'b0;
  int hold_count;
  result_t predicted;
  result_t observed;
  result_t wanted;
  request_row_t taken_row;

  // apply one request to the shadow store and return its result
  function automatic result_t apply_request(logic [spq_pkg::REQ_W-1:0] req,
                                            logic signed [spq_pkg::VALUE_W-1:0] value,
                                            logic [spq_pkg::PRIO_W-1:0] prio);
    result_t r;
    int pos;
    int i;
    r = '0;
    r.status = spq_pkg::ST_OK;
    case (req)
      spq_pkg::REQ_PUSH: begin
        if (shadow_count >= spq_pkg::CAPACITY) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          // new entry goes ahead of equal priorities
          pos = 0;
          while (pos < shadow_count && shadow_store[pos].prio > prio) pos++;
          for (i = shadow_count; i > pos; i--) shadow_store[i] = shadow_store[i-1];
          shadow_store[pos].value = value;
          shadow_store[pos].prio = prio;
          shadow_count++;
        end
      end
      spq_pkg::REQ_POP, spq_pkg::REQ_PEEK: begin
        if (shadow_count == 0) begin
          r.status = spq_pkg::ST_EMPTY;
        end else begin
          r.front = shadow_store[0].value;
          if (req == spq_pkg::REQ_POP) begin
            for (i = 1; i < shadow_count; i++) shadow_store[i-1] = shadow_store[i];
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    r.count = shadow_count[spq_pkg::ECOUNT_W-1:0];
    return r;
  endfunction

  // table entry helper; typed rows carry their answer
  task automatic add_row(logic [spq_pkg::REQ_W-1:0] req,
                         logic signed [spq_pkg::VALUE_W-1:0] value,
                         logic [spq_pkg::PRIO_W-1:0] prio, logic typed,
                         logic signed [spq_pkg::VALUE_W-1:0] front,
                         logic [spq_pkg::STATUS_W-1:0] status,
                         logic [spq_pkg::ECOUNT_W-1:0] count);
    request_row_t row;
    row.req = req;
    row.value = value;
    row.prio = prio;
    row.typed = typed;
    row.answer.front = front;
    row.answer.status = status;
    row.answer.count = count;
    directed_rows.push_back(row);
  endtask

  // priorities lean toward zero, all ones and values up to 7 so ties are common
  function automatic logic [spq_pkg::PRIO_W-1:0] pick_prio();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return spq_pkg::PRIO_W'($urandom_range(7));
      default: return spq_pkg::PRIO_W'($urandom);
    endcase
  endfunction

  // mode 0 fills, mode 1 drains, mode 2 mixes
  function automatic request_row_t make_random_row(int mode);
    request_row_t row;
    int roll;
    row = '0;
    roll = $urandom_range(99);
    row.value = $urandom;
    row.prio = pick_prio();
    if (roll < 5) begin
      row.req = REQ_NOP;
    end else if (roll < 15) begin
      row.req = spq_pkg::REQ_PEEK;
    end else begin
      case (mode)
        0: row.req = (roll < 80) ? spq_pkg::REQ_PUSH : spq_pkg::REQ_POP;
        1: row.req = (roll < 30) ? spq_pkg::REQ_PUSH : spq_pkg::REQ_POP;
        default: row.req = (roll < 57) ? spq_pkg::REQ_PUSH : spq_pkg::REQ_POP;
      endcase
    end
    return row;
  endfunction

  // offer one request and hold it until the transaction completes
  task automatic send_row(request_row_t row);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    rows_in_flight.push_back(row);
    in_tvalid <= 1'b1;
    in_tuser <= row.req;
    in_tdata <= {row.prio, row.value};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // result check, then prediction of the transaction taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        observed.front = out_tdata[31:0];
        observed.count = out_tdata[36:32];
        observed.status = out_tuser;
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: front %0d status %0d count %0d",
                   $time, observed.front, observed.status, observed.count);
          mismatches++;
        end else begin
          wanted = pending_results.pop_front();
          if (observed !== wanted || out_tdata[39:37] !== 3'b000) begin
            $write("%0t: expected front %0d status %0d count %0d, ",
                   $time, wanted.front, wanted.status, wanted.count);
            $display("got front %0d status %0d count %0d pad %b",
                     observed.front, observed.status, observed.count, out_tdata[39:37]);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predicted = apply_request(in_tuser, in_tdata[31:0], in_tdata[47:32]);
        taken_row = rows_in_flight.pop_front();
        pending_results.push_back(taken_row.typed ? taken_row.answer : predicted);
      end
    end
  end

  // result side readiness, with a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
          out_tready <= 1'b0;
          hold_count++;
          @(posedge clk);
        end
      end
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int phase;
    int sent;
    int burst_len;
    int burst_mode;
    request_row_t row;

    // empty queue, unused code, extremes, tie order, then fill to full
    add_row(spq_pkg::REQ_POP, 32'sh1234_5678, 16'h00FF, 1'b1, 0, spq_pkg::ST_EMPTY, 0);
    add_row(spq_pkg::REQ_PEEK, -1, 16'hFFFF, 1'b1, 0, spq_pkg::ST_EMPTY, 0);
    add_row(REQ_NOP, -1, 16'hFFFF, 1'b1, 0, spq_pkg::ST_OK, 0);
    add_row(spq_pkg::REQ_PUSH, 32'sh7FFF_FFFF, 16'h0000, 1'b1, 0, spq_pkg::ST_OK, 1);
    add_row(spq_pkg::REQ_PUSH, 32'sh8000_0000, 16'hFFFF, 1'b1, 0, spq_pkg::ST_OK, 2);
    add_row(spq_pkg::REQ_PUSH, 32'sd5, 16'hFFFF, 1'b1, 0, spq_pkg::ST_OK, 3);
    add_row(spq_pkg::REQ_PEEK, 0, 16'h0000, 1'b1, 32'sd5, spq_pkg::ST_OK, 3);
    add_row(spq_pkg::REQ_POP, 0, 16'h0000, 1'b1, 32'sd5, spq_pkg::ST_OK, 2);
    for (int k = 0; k < 14; k++) begin
      add_row(spq_pkg::REQ_PUSH, (k % 2) ? -k : (32'sh0F0F_0000 | k),
              spq_pkg::PRIO_W'((k % 5) * 16'h3FFF), 1'b0, 0, spq_pkg::ST_OK, 0);
    end
    add_row(spq_pkg::REQ_PUSH, 32'sd99, 16'hFFFF, 1'b1, 0, spq_pkg::ST_FULL, 16);
    add_row(REQ_NOP, 0, 16'h0000, 1'b1, 0, spq_pkg::ST_OK, 16);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0; sink_stall_pct = 0; end
        1: begin sender_idle_pct = 84; sink_stall_pct = 0; end
        2: begin sender_idle_pct = 0; sink_stall_pct = 84; end
        default: begin sender_idle_pct = 19; sink_stall_pct = 19; end
      endcase
      if (phase == 0) begin
        foreach (directed_rows[j]) send_row(directed_rows[j]);
        // long result stall while requests keep coming
        hold_pending = 1'b1;
      end
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        burst_mode = $urandom_range(2);
        burst_len = $urandom_range(8, 40);
        repeat (burst_len) begin
          row = make_random_row(burst_mode);
          send_row(row);
          if (row.req != REQ_NOP) sent++;
        end
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
